// ===== design/etg_pkg.sv =====
// Shared types and constants of the energy transient gesture detector.
// No dependencies; imported by every other file of the block.
package etg_pkg;

   localparam int unsigned ENERGY_W   = 16;
   localparam int unsigned ENV_W      = 32;
   localparam int unsigned ENV_FRAC_W = 16;
   localparam int unsigned WEIGHT_W   = 16;
   localparam int unsigned RATIO_W    = 11;
   localparam int unsigned RATIO_SH   = 24;
   localparam int unsigned NEW_W      = WEIGHT_W + ENERGY_W;
   localparam int unsigned DECAY_W    = WEIGHT_W + ENV_W;
   localparam int unsigned CMP_W      = ENV_W + RATIO_W;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [WEIGHT_W-1:0] W_OLD = 16'd64225;
   localparam logic [WEIGHT_W-1:0] W_NEW = 16'd1311;

   localparam logic [CSR_IDX_W-1:0] REG_SCAN_LENGTH   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_FLOOR = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_RATIO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_RATIO = 8'd3;

   localparam logic [15:0]        RST_SCAN_LENGTH   = 16'd24000;
   localparam logic [15:0]        RST_TRIGGER_FLOOR = 16'd983;
   localparam logic [RATIO_W-1:0] RST_TRIGGER_RATIO = 11'd512;
   localparam logic [RATIO_W-1:0] RST_RELEASE_RATIO = 11'd333;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SCAN = 2'd1,
      PH_LOCK = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCALE,
      BK_ENV,
      BK_RATIO,
      BK_UPDATE
   } back_step_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic [NEW_W-1:0]    weighted;
   } etg_item_type;

   typedef struct packed {
      logic [15:0]        scan_length;
      logic [15:0]        trigger_floor;
      logic [RATIO_W-1:0] trigger_ratio;
      logic [RATIO_W-1:0] release_ratio;
   } etg_cfg_type;

endpackage

// ===== design/etg_front.sv =====
// Front end: takes sample pair transfers, forms the unsigned Q1.15 energy and its new-sample term.
// Depends on etg_pkg.
module etg_front import etg_pkg::*; #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [SAMPLE_WIDTH-1:0]   left_sample,
   input  logic [SAMPLE_WIDTH-1:0]   right_sample,
   output logic                      out_valid,
   input  logic                      out_ready,
   output etg_item_type              out_item
);

   localparam int unsigned SUM_W = SAMPLE_WIDTH + 1;
   localparam int unsigned EXT_W = SUM_W + ENERGY_W;
   localparam int unsigned SH_R  = (SAMPLE_WIDTH > 15) ? SAMPLE_WIDTH - 15 : 0;
   localparam int unsigned SH_L  = (SAMPLE_WIDTH < 15) ? 15 - SAMPLE_WIDTH : 0;

   logic                     valid_ff, valid_in;
   etg_item_type             item_ff;
   logic [SAMPLE_WIDTH-1:0]  mag_l, mag_r;
   logic [SUM_W-1:0]         mag_sum;
   logic [EXT_W-1:0]         sum_ext;
   logic [ENERGY_W-1:0]      energy;
   logic                     take;

   // two's complement magnitude; the most negative code maps to 2^(w-1)
   assign mag_l   = left_sample[SAMPLE_WIDTH-1]  ? (~left_sample + 1'b1)  : left_sample;
   assign mag_r   = right_sample[SAMPLE_WIDTH-1] ? (~right_sample + 1'b1) : right_sample;
   assign mag_sum = SUM_W'(mag_l) + SUM_W'(mag_r);
   assign sum_ext = EXT_W'(mag_sum);
   assign energy  = ENERGY_W'((sum_ext >> SH_R) << SH_L);

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.energy   <= energy;
         item_ff.weighted <= NEW_W'(W_NEW) * NEW_W'(energy);
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== design/etg_queue.sv =====
// Two-entry queue decoupling the front end from the envelope/state back end.
// Depends on etg_pkg.
module etg_queue import etg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  etg_item_type  push_item,
   output logic          pop_valid,
   input  logic          pop,
   output etg_item_type  pop_item
);

   etg_item_type  slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/etg_back.sv =====
// Back end: envelope update over four steps, detector state machine, result register.
// Depends on etg_pkg.
module etg_back import etg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  etg_cfg_type            cfg,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  etg_item_type           q_item,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   back_step_type          step_ff, step_in;
   phase_type              phase_ff, phase_in;
   logic [ENV_W-1:0]       envelope_ff;
   logic [15:0]            count_ff, count_in;
   logic [ENERGY_W-1:0]    captured_ff, captured_in;
   etg_item_type           item_ff;
   logic [DECAY_W-1:0]     decay_ff;
   logic [ENV_W-1:0]       env_calc_ff;
   logic [CMP_W-1:0]       ratio_prod_ff;
   logic [RATIO_W-1:0]     ratio_sel;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic                   out_free, fire;
   logic [CMP_W-1:0]       e24;
   logic                   above, below;
   logic [15:0]            count_inc;
   logic                   lock;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer next step
   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         BK_IDLE:   step_in = q_valid ? BK_SCALE : BK_IDLE;
         BK_SCALE:  step_in = BK_ENV;
         BK_ENV:    step_in = BK_RATIO;
         BK_RATIO:  step_in = BK_UPDATE;
         BK_UPDATE: begin
            if (out_free) begin
               step_in = q_valid ? BK_SCALE : BK_IDLE;
            end
         end
         default:   step_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop = 1'b0;
      fire  = 1'b0;
      unique case (step_ff)
         BK_IDLE:   q_pop = q_valid;
         BK_UPDATE: begin
            fire  = out_free;
            q_pop = out_free && q_valid;
         end
         default: begin
            q_pop = 1'b0;
            fire  = 1'b0;
         end
      endcase
   end

   assign ratio_sel = (phase_ff == PH_SCAN) ? cfg.release_ratio : cfg.trigger_ratio;
   assign e24       = CMP_W'({item_ff.energy, {RATIO_SH{1'b0}}});
   assign above     = e24 > ratio_prod_ff;
   assign below     = e24 < ratio_prod_ff;
   assign count_inc = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;

   // detector state machine
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      captured_in = captured_ff;
      lock        = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (above && (item_ff.energy > cfg.trigger_floor)) begin
               phase_in = PH_SCAN;
               count_in = 16'd0;
            end
         end
         PH_SCAN: begin
            count_in = count_inc;
            lock = (count_inc >= cfg.scan_length) ||
                   (below && (count_inc > (cfg.scan_length >> 1)));
            if (lock) begin
               phase_in    = PH_LOCK;
               captured_in = item_ff.energy;
            end
         end
         default: phase_in = PH_LOCK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= BK_IDLE;
         phase_ff     <= PH_IDLE;
         envelope_ff  <= '0;
         count_ff     <= '0;
         captured_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (fire) begin
            phase_ff     <= phase_in;
            envelope_ff  <= env_calc_ff;
            count_ff     <= count_in;
            captured_ff  <= captured_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (step_ff == BK_SCALE) begin
         decay_ff <= DECAY_W'(W_OLD) * DECAY_W'(envelope_ff);
      end
      if (step_ff == BK_ENV) begin
         env_calc_ff <= ENV_W'(decay_ff >> ENV_FRAC_W) + ENV_W'(item_ff.weighted);
      end
      if (step_ff == BK_RATIO) begin
         ratio_prod_ff <= CMP_W'(env_calc_ff) * CMP_W'(ratio_sel);
      end
      if (fire) begin
         rsp_data_ff <= RSP_DATA_W'({env_calc_ff[ENV_W-1:ENV_FRAC_W], captured_in,
                                     phase_in});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/energy_transient_gesture_detector.sv =====
// Channel | ports                         | payload
// req     | req_tvalid/tready/tdata       | left_sample, right_sample
// rsp     | rsp_tvalid/tready/tdata       | detector_state, locked_energy, envelope_level
// csr     | csr_valid/ready/index/data    | scan_length, trigger_floor, *_ratio
// One result per sample pair. The back end works each item in order through a decay multiply,
// envelope sum, ratio multiply and state update, and takes no new item before the state update
// of the current one, which waits while rsp holds an untaken result. Between a req transfer and
// rsp_tvalid lie the front-end register, a queue slot, the back-end item register and these steps.
// A two-entry queue between front and back lets input transfers continue while a result waits.
// Synchronous active-high reset clears state and restores register defaults. CSR writes are always accepted.
// Top level of the detector; depends on etg_pkg, etg_front, etg_queue, etg_back.
module energy_transient_gesture_detector import etg_pkg::*; #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // left_sample, right_sample
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // detector_state [1:0], locked_energy [17:2], envelope_level [33:18]
   output logic [RSP_DATA_W-1:0]                   rsp_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [CSR_IDX_W-1:0]                    csr_index,
   input  logic [CSR_DATA_W-1:0]                   csr_data
);

   etg_cfg_type   cfg_ff;
   logic          f_valid, f_ready;
   etg_item_type  f_item;
   logic          q_valid, q_pop;
   etg_item_type  q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_length   <= RST_SCAN_LENGTH;
         cfg_ff.trigger_floor <= RST_TRIGGER_FLOOR;
         cfg_ff.trigger_ratio <= RST_TRIGGER_RATIO;
         cfg_ff.release_ratio <= RST_RELEASE_RATIO;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SCAN_LENGTH:   cfg_ff.scan_length   <= csr_data;
            REG_TRIGGER_FLOOR: cfg_ff.trigger_floor <= csr_data;
            REG_TRIGGER_RATIO: cfg_ff.trigger_ratio <= csr_data[RATIO_W-1:0];
            REG_RELEASE_RATIO: cfg_ff.release_ratio <= csr_data[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   etg_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .left_sample  (req_tdata[SAMPLE_WIDTH-1:0]),
      .right_sample (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_item     (f_item)
   );

   etg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   etg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/sv/etg_checker.sv =====
`timescale 1ns / 1ps
// Checker for the energy transient gesture detector: watches req, rsp and csr transfers,
// predicts each result and compares it field by field. Depends on etg_pkg.
module etg_checker import etg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      phase_type           state;
      logic [ENERGY_W-1:0] locked;
      logic [15:0]         level;
   } detector_result_type;

   etg_cfg_type         cfg;
   phase_type           det_phase;
   logic [ENV_W-1:0]    env_acc;
   logic [15:0]         scan_cnt;
   logic [ENERGY_W-1:0] captured;
   detector_result_type expected_q[$];

   function automatic logic [16:0] sample_mag(logic [15:0] s);
      return s[15] ? (~{1'b1, s}) + 17'd1 : {1'b0, s};
   endfunction

   // Advances the detector state by one sample pair and returns the result it shows.
   function automatic detector_result_type step_detector(logic [15:0] left,
                                                         logic [15:0] right);
      logic [17:0]         mag_sum;
      logic [ENERGY_W-1:0] energy;
      logic [63:0]         blend, e24;
      logic                lock;
      detector_result_type res;
      mag_sum = 18'(sample_mag(left)) + 18'(sample_mag(right));
      energy = mag_sum[16:1];
      blend = 64'(W_OLD) * 64'(env_acc) + 64'(W_NEW) * (64'(energy) << ENV_FRAC_W);
      env_acc = ENV_W'(blend >> ENV_FRAC_W);
      e24 = 64'(energy) << RATIO_SH;
      case (det_phase)
         PH_IDLE: begin
            if (e24 > 64'(env_acc) * 64'(cfg.trigger_ratio) && energy > cfg.trigger_floor) begin
               det_phase = PH_SCAN;
               scan_cnt = '0;
            end
         end
         PH_SCAN: begin
            if (scan_cnt != 16'hFFFF) scan_cnt = scan_cnt + 16'd1;
            lock = scan_cnt >= cfg.scan_length;
            if (e24 < 64'(env_acc) * 64'(cfg.release_ratio) && scan_cnt > (cfg.scan_length >> 1))
               lock = 1'b1;
            if (lock) begin
               captured = energy;
               det_phase = PH_LOCK;
            end
         end
         default: det_phase = PH_LOCK;
      endcase
      res.state = det_phase;
      res.locked = captured;
      res.level = env_acc[31:16];
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      detector_result_type want;
      int                  errs;
      errs = 0;
      if (reset) begin
         cfg.scan_length = RST_SCAN_LENGTH;
         cfg.trigger_floor = RST_TRIGGER_FLOOR;
         cfg.trigger_ratio = RST_TRIGGER_RATIO;
         cfg.release_ratio = RST_RELEASE_RATIO;
         det_phase = PH_IDLE;
         env_acc = '0;
         scan_cnt = '0;
         captured = '0;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SCAN_LENGTH:   cfg.scan_length = csr_data;
               REG_TRIGGER_FLOOR: cfg.trigger_floor = csr_data;
               REG_TRIGGER_RATIO: cfg.trigger_ratio = csr_data[RATIO_W-1:0];
               REG_RELEASE_RATIO: cfg.release_ratio = csr_data[RATIO_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(step_detector(req_tdata[15:0], req_tdata[31:16]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("rsp transfer with no result expected: tdata %h", rsp_tdata);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[1:0] !== want.state) begin
                  $error("detector_state: expected %0d, got %0d", want.state, rsp_tdata[1:0]);
                  errs++;
               end
               if (rsp_tdata[17:2] !== want.locked) begin
                  $error("locked_energy: expected %0d, got %0d", want.locked, rsp_tdata[17:2]);
                  errs++;
               end
               if (rsp_tdata[33:18] !== want.level) begin
                  $error("envelope_level: expected %0d, got %0d", want.level, rsp_tdata[33:18]);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= expected_q.size();
      end
   end

endmodule

// ===== tb/sv/tb_energy_transient_gesture_detector.sv =====
`timescale 1ns / 1ps
// Top testbench of the energy transient gesture detector: clock, reset, stimulus and verdict.
// Depends on etg_pkg, the detector RTL and etg_checker.
module tb_energy_transient_gesture_detector;
   import etg_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   typedef enum int {
      LOCK_ZERO_LEN,
      LOCK_SHORTENED,
      LOCK_RELEASE,
      LOCK_COUNT
   } lock_path_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    pending_results;
   int                    burst_left = 0;
   int                    cycle_count = 0;
   int                    ready_mode = 0;
   int                    ready_count = 0;
   logic [7:0]            ready_mask = 8'hFF;

   // {right, left}
   logic [31:0] corner_pairs [16] = '{
      32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000,
      32'h8000_7FFF, 32'hFFFF_FFFF, 32'h0001_0001, 32'h0001_FFFF,
      32'hFFFF_0001, 32'h8000_0000, 32'h0000_8000, 32'h0000_0001,
      32'hC000_4000, 32'h8001_8001, 32'hFF9C_0064, 32'h5555_AAAA
   };

   energy_transient_gesture_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   etg_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending_results)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // rsp side runs in windows of random length, each with its own pattern: always ready or stalling
   always @(posedge clock) begin
      if (ready_count == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_mask <= 8'($urandom) | 8'h01;
         ready_count <= $urandom_range(20, 80);
      end else begin
         ready_count <= ready_count - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ready_mask[ready_count % 8];
      endcase
   end

   function automatic logic [15:0] rand_sample();
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = $urandom_range(0, 1) ? 32767 : -32768;
         2, 3: v = $urandom_range(0, 65535);
         4, 5: begin
            v = $urandom_range(0, 2046);
            v = v - 1023;
         end
         default: begin
            v = $urandom_range(0, 16382);
            v = v - 8191;
         end
      endcase
      return 16'(v);
   endfunction

   function automatic logic [15:0] quiet_sample();
      int v;
      v = $urandom_range(0, 400);
      return 16'(v - 200);
   endfunction

   function automatic logic [15:0] loud_sample();
      int v;
      v = $urandom_range(16384, 32767);
      return $urandom_range(0, 1) ? 16'(v) : 16'(-v);
   endfunction

   // One req transfer; the sender runs in bursts with random gaps between them.
   task automatic send_pair(input logic [15:0] left, input logic [15:0] right);
      int gap;
      req_tdata <= {right, left};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      if (req_tvalid) req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) == 0) drain_results();
         send_pair(rand_sample(), rand_sample());
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      lock_path_type lock_path;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners while a scan cannot start: floor above full scale
      write_reg(8'd4, 16'hFFFF);
      write_reg(8'hFF, 16'h0000);
      write_reg(REG_TRIGGER_FLOOR, 16'hFFFF);
      write_reg(REG_TRIGGER_RATIO, 16'd0);
      write_reg(REG_RELEASE_RATIO, 16'd0);
      write_reg(REG_SCAN_LENGTH, 16'd1);
      foreach (corner_pairs[i]) send_pair(corner_pairs[i][15:0], corner_pairs[i][31:16]);

      // envelope build-up, still idle: floor at full scale
      write_reg(REG_TRIGGER_FLOOR, 16'd32768);
      write_reg(REG_TRIGGER_RATIO, 16'd2047);
      send_random(200);
      write_reg(REG_TRIGGER_RATIO, 16'hFFFF);
      send_random(200);

      // quiet stretch then a transient starts the scan
      write_reg(REG_SCAN_LENGTH, 16'hFFFF);
      write_reg(REG_RELEASE_RATIO, 16'd0);
      write_reg(REG_TRIGGER_FLOOR, 16'($urandom_range(0, 2000)));
      write_reg(REG_TRIGGER_RATIO, 16'($urandom_range(256, 1023)));
      for (int i = 0; i < 60; i++) send_pair(quiet_sample(), quiet_sample());
      for (int i = 0; i < 8; i++) send_pair(loud_sample(), loud_sample());
      send_random(400);

      // registers changed mid-scan to force a lock
      lock_path = lock_path_type'($urandom_range(0, 3));
      case (lock_path)
         LOCK_ZERO_LEN:  write_reg(REG_SCAN_LENGTH, 16'd0);
         LOCK_SHORTENED: write_reg(REG_SCAN_LENGTH, 16'd1);
         LOCK_RELEASE: begin
            write_reg(REG_SCAN_LENGTH, 16'd900);
            write_reg(REG_RELEASE_RATIO, 16'hFFFF);
         end
         default: write_reg(REG_SCAN_LENGTH, 16'd600);
      endcase
      send_random(200);

      // locked holds whatever the registers say
      write_reg(REG_TRIGGER_FLOOR, 16'd0);
      write_reg(REG_TRIGGER_RATIO, 16'd0);
      write_reg(REG_RELEASE_RATIO, 16'd2047);
      write_reg(REG_SCAN_LENGTH, 16'd65535);
      send_random(150);
      write_reg(REG_RELEASE_RATIO, 16'(RST_RELEASE_RATIO));
      write_reg(REG_SCAN_LENGTH, 16'd1);
      send_random(150);

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
